/* rtl/kmp_pkg.sv */
package kmp_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int MAX_TEXT    = 65536;

  localparam int PAT_AW = $clog2(MAX_PATTERN);
  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int TP_W   = $clog2(MAX_TEXT + 1);
  localparam int CHAR_W = 8;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 3;
  localparam int POS_W  = 16;
  localparam int CNT_W  = 7;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TEXT   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] ST_ACCEPT    = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_MATCH  = 3'd1;
  localparam logic [STAT_W-1:0] ST_MATCH     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_ERROR     = 3'd4;

  // Read and write requests toward the pattern and failure memories
  typedef struct packed {
    logic              pat_we;
    logic [PAT_AW-1:0] pat_waddr;
    logic [CHAR_W-1:0] pat_wdata;
    logic [PAT_AW-1:0] pat_raddr;
    logic              fail_we;
    logic [PAT_AW-1:0] fail_waddr;
    logic [PAT_AW-1:0] fail_wdata;
    logic [PAT_AW-1:0] fail_raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  count;
  } res_t;

endpackage

/* rtl/kmp_ram.sv */
module kmp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/kmp_seq.sv */
module kmp_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kmp_pkg::REQ_W-1:0]     req_type_i,
  input  logic [kmp_pkg::CHAR_W-1:0]    char_value_i,
  input  logic                          last_text_i,
  input  logic [kmp_pkg::CHAR_W-1:0]    pat_rdata_i,
  input  logic [kmp_pkg::PAT_AW-1:0]    fail_rdata_i,
  output kmp_pkg::mem_req_t             mem_o,
  input  logic                          out_free_i,
  output kmp_pkg::res_t                 res_o
);
  import kmp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SEED = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [REQ_W-1:0]  req_q, req_d;
  logic [CHAR_W-1:0] c_q, c_d;
  logic              last_q, last_d;
  logic [PAT_AW-1:0] k_q, k_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  mp_q, mp_d;
  logic [TP_W-1:0]   tp_q, tp_d;
  logic              found_q, found_d;
  logic [POS_W-1:0]  fpos_q, fpos_d;
  logic [STAT_W-1:0] st_q, st_d;
  logic [POS_W-1:0]  pos_q, pos_d;

  logic              eq;
  logic [PAT_AW-1:0] k_start;
  logic [LEN_W-1:0]  new_k;
  logic [TP_W-1:0]   tp_inc;
  logic [POS_W-1:0]  hit_pos;

  assign eq      = (pat_rdata_i == c_q);
  assign k_start = (mp_q >= len_q) ? '0 : PAT_AW'(mp_q);
  assign new_k   = eq ? LEN_W'(k_q) + LEN_W'(1) : LEN_W'(k_q);
  assign tp_inc  = tp_q + TP_W'(1);
  assign hit_pos = POS_W'(tp_inc - TP_W'(len_q));

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    c_d     = c_q;
    last_d  = last_q;
    k_d     = k_q;
    len_d   = len_q;
    mp_d    = mp_q;
    tp_d    = tp_q;
    found_d = found_q;
    fpos_d  = fpos_q;
    st_d    = st_q;
    pos_d   = pos_q;
    mem_o   = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d  = req_type_i;
          c_d    = char_value_i;
          last_d = last_text_i;
          pos_d  = '0;
          st_d   = ST_ACCEPT;
          state_d = S_OUT;
          unique case (req_type_i)
            REQ_APPEND: begin
              if (len_q >= LEN_W'(MAX_PATTERN)) begin
                st_d = ST_ERROR;
              end else begin
                mem_o.pat_we    = 1'b1;
                mem_o.pat_waddr = PAT_AW'(len_q);
                mem_o.pat_wdata = char_value_i;
                if (len_q == '0) begin
                  mem_o.fail_we    = 1'b1;
                  mem_o.fail_waddr = '0;
                  mem_o.fail_wdata = '0;
                  len_d = LEN_W'(1);
                end else begin
                  state_d = S_SEED;
                end
              end
            end
            REQ_TEXT: begin
              if (found_q) begin
                st_d  = ST_MATCH;
                pos_d = fpos_q;
              end else if (len_q == '0) begin
                found_d = 1'b1;
                fpos_d  = '0;
                st_d    = ST_MATCH;
              end else if (tp_q >= TP_W'(MAX_TEXT)) begin
                st_d = ST_ERROR;
              end else begin
                k_d     = k_start;
                state_d = S_CMP;
              end
            end
            REQ_START: begin
              mp_d    = '0;
              tp_d    = '0;
              found_d = 1'b0;
              fpos_d  = '0;
            end
            REQ_CLEAR: begin
              len_d = '0;
              mp_d  = '0;
            end
            default: ;
          endcase
        end
      end
      S_SEED: begin
        // failure entry of the last loaded byte is the first candidate border
        k_d     = fail_rdata_i;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (k_q != '0 && !eq) begin
          k_d = fail_rdata_i;
        end else begin
          state_d = S_OUT;
          if (req_q == REQ_APPEND) begin
            mem_o.fail_we    = 1'b1;
            mem_o.fail_waddr = PAT_AW'(len_q);
            mem_o.fail_wdata = eq ? k_q + PAT_AW'(1) : '0;
            len_d = len_q + LEN_W'(1);
            st_d  = ST_ACCEPT;
          end else begin
            mp_d = new_k;
            tp_d = tp_inc;
            if (new_k == len_q) begin
              found_d = 1'b1;
              fpos_d  = hit_pos;
              st_d    = ST_MATCH;
              pos_d   = hit_pos;
            end else begin
              st_d = last_q ? ST_NOT_FOUND : ST_NO_MATCH;
            end
          end
        end
      end
      S_OUT: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Reads follow the next candidate prefix; the seed read looks up the
    // failure entry of the last loaded byte instead.
    mem_o.pat_raddr  = k_d;
    mem_o.fail_raddr = k_d - PAT_AW'(1);
    if (state_q == S_IDLE && req_type_i == REQ_APPEND) begin
      mem_o.fail_raddr = PAT_AW'(len_q - LEN_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      mp_q    <= '0;
      tp_q    <= '0;
      found_q <= 1'b0;
      fpos_q  <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      mp_q    <= mp_d;
      tp_q    <= tp_d;
      found_q <= found_d;
      fpos_q  <= fpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    c_q    <= c_d;
    last_q <= last_d;
    k_q    <= k_d;
    st_q   <= st_d;
    pos_q  <= pos_d;
  end

  assign res_o.valid    = (state_q == S_OUT);
  assign res_o.status   = st_q;
  assign res_o.position = pos_q;
  assign res_o.count    = CNT_W'(len_q);

  a_prefix_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mp_q <= len_q)
    else $error("matched prefix beyond pattern length");

  a_unfound_prefix_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> (mp_q < len_q || len_q == '0))
    else $error("full match without found flag");

  a_cmp_candidate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> LEN_W'(k_q) < len_q)
    else $error("candidate prefix outside loaded pattern");

  a_border_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.fail_we |-> mem_o.fail_wdata <= mem_o.fail_waddr)
    else $error("failure entry not a proper border");

  a_seed_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEED |=> state_q == S_CMP)
    else $error("seed read not followed by compare");

endmodule

/* rtl/kmp_substring_search_core.sv */
// Knuth-Morris-Pratt first-match search engine.
// Input channel (in_valid_i/in_ready_o): one request item per transfer,
// req_type_i selects append pattern byte, text byte, start search or clear.
// Output channel (out_valid_o/out_ready_i): exactly one result item per
// request: status, start position of the first match and pattern count.
// Pattern bytes and their failure entries live in two 64-entry RAMs with a
// registered read; the failure entry of a new byte is found on append.
// One item at a time: a new request is taken only in the idle state. Start,
// clear, errors, held matches and the first append go from accept straight
// to the result state and then the output register. A text byte passes the
// compare state first, once plus once per extra failure step; a later
// append adds one seed read before its compare. The failure walk is
// amortized under two steps per text byte.
// The walk is one RAM read round trip per step: that loop sets the rate.
// Reset clears pattern length, search position and found state; RAM
// contents are undefined but never read before being written.
// A stalled receiver holds the result in the output register; the engine
// finishes the next item and then waits for the output register to free.
module kmp_substring_search_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kmp_pkg::REQ_W-1:0]     req_type_i,
  input  logic [kmp_pkg::CHAR_W-1:0]    char_value_i,
  input  logic                          last_text_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kmp_pkg::STAT_W-1:0]    status_o,
  output logic [kmp_pkg::POS_W-1:0]     match_position_o,
  output logic [kmp_pkg::CNT_W-1:0]     pattern_count_o
);
  import kmp_pkg::*;

  mem_req_t          mem_req;
  res_t              res;
  logic [CHAR_W-1:0] pat_rdata;
  logic [PAT_AW-1:0] fail_rdata;
  logic              out_free;

  logic              out_valid_q;
  logic [STAT_W-1:0] status_q;
  logic [POS_W-1:0]  position_q;
  logic [CNT_W-1:0]  count_q;

  assign out_free = !out_valid_q || out_ready_i;

  kmp_ram #(
    .Width(CHAR_W),
    .Depth(MAX_PATTERN)
  ) u_pat_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.pat_we),
    .waddr_i(mem_req.pat_waddr),
    .wdata_i(mem_req.pat_wdata),
    .raddr_i(mem_req.pat_raddr),
    .rdata_o(pat_rdata)
  );

  kmp_ram #(
    .Width(PAT_AW),
    .Depth(MAX_PATTERN)
  ) u_fail_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.fail_we),
    .waddr_i(mem_req.fail_waddr),
    .wdata_i(mem_req.fail_wdata),
    .raddr_i(mem_req.fail_raddr),
    .rdata_o(fail_rdata)
  );

  kmp_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .char_value_i(char_value_i),
    .last_text_i (last_text_i),
    .pat_rdata_i (pat_rdata),
    .fail_rdata_i(fail_rdata),
    .mem_o       (mem_req),
    .out_free_i  (out_free),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && out_free) begin
      status_q   <= res.status;
      position_q <= res.position;
      count_q    <= res.count;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign match_position_o = position_q;
  assign pattern_count_o  = count_q;

endmodule

/* dv/kmp_substring_search_core_test.sv */
`timescale 1ns / 1ps

module kmp_substring_search_core_test;
  import kmp_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int HOLD_CYCLES     = 400;
  localparam int PHASE_ITEMS     = 440;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } search_req_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
  } search_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [REQ_W-1:0]  req_type_i = REQ_CLEAR;
  logic [CHAR_W-1:0] char_value_i = '0;
  logic              last_text_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [STAT_W-1:0] status_o;
  logic [POS_W-1:0]  match_position_o;
  logic [CNT_W-1:0]  pattern_count_o;

  kmp_substring_search_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .char_value_i     (char_value_i),
    .last_text_i      (last_text_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .match_position_o (match_position_o),
    .pattern_count_o  (pattern_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  search_req_t request_q[$];
  search_res_t expected_q[$];
  search_req_t drv_item;
  search_req_t mon_item;
  search_res_t exp_res;
  search_res_t acc_res;
  int          err_cnt = 0;
  int          pushed = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  // Search engine mirror
  logic [CHAR_W-1:0] pat_bytes [MAX_PATTERN];
  logic [LEN_W-1:0]  pat_border [MAX_PATTERN];
  logic [LEN_W-1:0]  pat_len = '0;
  logic [LEN_W-1:0]  prefix_len = '0;
  logic [TP_W-1:0]   text_pos = '0;
  logic              found = 1'b0;
  logic [POS_W-1:0]  found_pos = '0;

  task automatic search_step(input search_req_t it, output search_res_t r);
    logic [LEN_W-1:0] k;
    logic [LEN_W-1:0] j;
    logic [TP_W-1:0]  start_idx;
    r.status = ST_ACCEPT;
    r.pos    = '0;
    case (it.req)
      REQ_APPEND: begin
        if (pat_len >= MAX_PATTERN) begin
          r.status = ST_ERROR;
        end else begin
          j = pat_len;
          pat_bytes[j] = it.ch;
          k = '0;
          if (j != 0) begin
            k = pat_border[j - 1];
            while (k != 0 && pat_bytes[k] != it.ch) k = pat_border[k - 1];
            k = (pat_bytes[k] == it.ch) ? k + 1'b1 : '0;
          end
          pat_border[j] = k;
          pat_len = j + 1'b1;
        end
      end
      REQ_TEXT: begin
        if (found) begin
          r.status = ST_MATCH;
          r.pos    = found_pos;
        end else if (pat_len == 0) begin
          found     = 1'b1;
          found_pos = '0;
          r.status  = ST_MATCH;
        end else if (text_pos >= MAX_TEXT) begin
          r.status = ST_ERROR;
        end else begin
          k = prefix_len;
          if (k >= pat_len) k = '0;
          while (k != 0 && pat_bytes[k] != it.ch) k = pat_border[k - 1];
          if (k < pat_len && pat_bytes[k] == it.ch) k = k + 1'b1;
          prefix_len = k;
          text_pos   = text_pos + 1'b1;
          if (prefix_len >= pat_len) begin
            found     = 1'b1;
            start_idx = text_pos - TP_W'(pat_len);
            found_pos = start_idx[POS_W-1:0];
            r.status  = ST_MATCH;
            r.pos     = found_pos;
          end else begin
            r.status = it.last ? ST_NOT_FOUND : ST_NO_MATCH;
          end
        end
      end
      REQ_START: begin
        prefix_len = '0;
        text_pos   = '0;
        found      = 1'b0;
        found_pos  = '0;
      end
      default: begin
        pat_len    = '0;
        prefix_len = '0;
      end
    endcase
    r.count = pat_len;
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = request_q.pop_front();
        in_valid_i   <= 1'b1;
        req_type_i   <= drv_item.req;
        char_value_i <= drv_item.ch;
        last_text_i  <= drv_item.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver, with an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check results, then predict for newly accepted items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: status %0d position %0d count %0d",
                 status_o, match_position_o, pattern_count_o);
          err_cnt++;
        end else begin
          exp_res = expected_q.pop_front();
          if (status_o !== exp_res.status) begin
            $error("status mismatch: expected %0d, got %0d", exp_res.status, status_o);
            err_cnt++;
          end
          if (match_position_o !== exp_res.pos) begin
            $error("match_position mismatch: expected %0d, got %0d",
                   exp_res.pos, match_position_o);
            err_cnt++;
          end
          if (pattern_count_o !== exp_res.count) begin
            $error("pattern_count mismatch: expected %0d, got %0d",
                   exp_res.count, pattern_count_o);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        mon_item.req  = req_type_i;
        mon_item.ch   = char_value_i;
        mon_item.last = last_text_i;
        search_step(mon_item, acc_res);
        expected_q.push_back(acc_res);
      end
    end
  end

  // Watchdog: only counts while work is outstanding
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (request_q.size() == 0 && expected_q.size() == 0 && !in_valid_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_item(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                           input logic lst);
    search_req_t it;
    it.req  = req;
    it.ch   = ch;
    it.last = lst;
    request_q.push_back(it);
    pushed++;
  endtask

  // start and clear carry don't-care fields, randomized anyway
  task automatic push_ctl(input logic [REQ_W-1:0] req);
    push_item(req, CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // One search: optional clear, pattern load, optional start, text stream
  task automatic gen_search();
    logic [CHAR_W-1:0] a;
    logic [CHAR_W-1:0] b;
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] pat[$];
    int                plen;
    int                pre;
    int                tlen;
    int                r;
    logic              embed;
    a = CHAR_W'($urandom_range(255));
    b = CHAR_W'($urandom_range(255));
    if ($urandom_range(4) != 0) push_ctl(REQ_CLEAR);
    r = $urandom_range(19);
    if (r == 0) plen = $urandom_range(60, 67);
    else if (r == 1) plen = 0;
    else plen = $urandom_range(1, 6);
    for (int i = 0; i < plen; i++) begin
      c = $urandom_range(1) ? a : b;
      pat.push_back(c);
      push_item(REQ_APPEND, c, 1'($urandom_range(1)));
    end
    if ($urandom_range(7) != 0) push_ctl(REQ_START);
    embed = $urandom_range(1) && plen > 0 && plen <= MAX_PATTERN;
    pre = $urandom_range(0, 12);
    tlen = embed ? pre + plen + $urandom_range(0, 6) : $urandom_range(1, 30);
    for (int i = 0; i < tlen; i++) begin
      if (embed && i >= pre && i < pre + plen) c = pat[i - pre];
      else if ($urandom_range(15) == 0) c = CHAR_W'($urandom_range(255));
      else c = $urandom_range(1) ? a : b;
      // pattern grows while a search is under way
      if ($urandom_range(29) == 0)
        push_item(REQ_APPEND, $urandom_range(1) ? a : b, 1'($urandom_range(1)));
      push_item(REQ_TEXT, c, i == tlen - 1);
    end
  endtask

  task automatic drain();
    while (request_q.size() != 0 || expected_q.size() != 0 || in_valid_i)
      @(negedge clk_i);
  endtask

  task automatic run_random(input int idle, input int stall, input logic long_hold);
    int target;
    target = pushed + PHASE_ITEMS;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    while (pushed < target) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6))
          push_item(REQ_W'($urandom_range(3)), CHAR_W'($urandom_range(255)),
                    1'($urandom_range(1)));
      end else begin
        gen_search();
      end
    end
    if (long_hold) hold_req = ~hold_req;
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: text before start, held match, clear keeps the match,
    // empty pattern, append mid-search with a failure walk, not found
    push_item(REQ_APPEND, 8'hFF, 1'b0);
    push_item(REQ_TEXT, 8'h00, 1'b0);
    push_item(REQ_TEXT, 8'hFF, 1'b1);
    push_item(REQ_TEXT, 8'h00, 1'b1);
    push_ctl(REQ_CLEAR);
    push_item(REQ_TEXT, 8'h12, 1'b0);
    push_ctl(REQ_START);
    push_item(REQ_TEXT, 8'h00, 1'b0);
    push_ctl(REQ_START);
    push_item(REQ_APPEND, 8'h00, 1'b1);
    push_item(REQ_APPEND, 8'hFF, 1'b0);
    push_item(REQ_APPEND, 8'h00, 1'b1);
    push_item(REQ_TEXT, 8'h00, 1'b0);
    push_item(REQ_TEXT, 8'hFF, 1'b0);
    push_item(REQ_APPEND, 8'hFF, 1'b0);
    push_item(REQ_TEXT, 8'h00, 1'b0);
    push_item(REQ_TEXT, 8'h00, 1'b0);
    push_item(REQ_TEXT, 8'hFF, 1'b0);
    push_item(REQ_TEXT, 8'h00, 1'b0);
    push_item(REQ_TEXT, 8'hFF, 1'b1);
    push_ctl(REQ_START);
    push_item(REQ_TEXT, 8'h55, 1'b1);
    push_item(REQ_TEXT, 8'h00, 1'b0);
    drain();

    run_random(0, 0, 1'b1);
    run_random(68, 0, 1'b0);
    run_random(0, 68, 1'b0);
    run_random(10, 10, 1'b0);

    repeat (20) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/kmp_pkg.sv
rtl/kmp_ram.sv
rtl/kmp_seq.sv
rtl/kmp_substring_search_core.sv
dv/kmp_substring_search_core_test.sv
